FILE: rtl/pws_pkg.sv
package pws_pkg;

   localparam int PHASE_BITS_DEF  = 16;
   localparam int SAMPLE_BITS_DEF = 16;
   localparam int TABLE_BITS_DEF  = 10;

   localparam int  SHAPE_BITS = 3;
   localparam real HALF_PI    = 1.5707963267948966;

   typedef enum logic [SHAPE_BITS-1:0] {
      SHAPE_SINE = 3'd0,
      SHAPE_RECT = 3'd1,
      SHAPE_SAW  = 3'd2,
      SHAPE_ISAW = 3'd3,
      SHAPE_TRI  = 3'd4,
      SHAPE_SQR  = 3'd5,
      SHAPE_CUBE = 3'd6,
      SHAPE_ZERO = 3'd7
   } shape_type;

endpackage

FILE: rtl/pws_req_if.sv
interface pws_req_if #(
   parameter int PHASE_BITS = pws_pkg::PHASE_BITS_DEF
);
   logic                  valid;
   logic                  ready;
   logic [PHASE_BITS-1:0] phase;

   modport source (output valid, output phase, input ready);
   modport sink   (input valid, input phase, output ready);
endinterface

FILE: rtl/pws_rsp_if.sv
interface pws_rsp_if #(
   parameter int SAMPLE_BITS = pws_pkg::SAMPLE_BITS_DEF
);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] sample;

   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

FILE: rtl/pws_sine_rom.sv
module pws_sine_rom
   import pws_pkg::*;
#(
   parameter int TABLE_BITS  = TABLE_BITS_DEF,
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   rd_en,
   input  logic [TABLE_BITS:0]    rd_addr,
   output logic [SAMPLE_BITS-2:0] rd_data
);

   localparam int  TblN  = 1 << TABLE_BITS;
   localparam real MaxR  = real'((1 << (SAMPLE_BITS - 1)) - 1);
   localparam real StepR = HALF_PI / real'(TblN);

   typedef logic [SAMPLE_BITS-2:0] tbl_type [TblN+1];

   // quarter wave, round(max * sin), entries 0 .. N inclusive
   function automatic tbl_type build_tbl();
      tbl_type t;
      real     x;
      for (int k = 0; k <= TblN; k++) begin
         x    = $floor(MaxR * $sin(StepR * real'(k)) + 0.5);
         t[k] = (SAMPLE_BITS-1)'($rtoi(x));
      end
      return t;
   endfunction

   localparam tbl_type SINE_TBL = build_tbl();

   logic [SAMPLE_BITS-2:0] data_ff;

   always_ff @(posedge clock) begin
      if (rd_en) begin
         data_ff <= SINE_TBL[rd_addr];
      end
   end

   assign rd_data = data_ff;

endmodule

FILE: rtl/periodic_waveform_shaper.sv
// Periodic waveform shaper: each item on req_if carries a phase word covering one
// period and yields one signed Q1.(SAMPLE_BITS-1) sample of the shape held in the
// csr register (sine, rectangular, sawtooth, inverse sawtooth, triangle, sine
// squared, sine cubed, zero). The datapath is a five-stage pipeline: index and
// simple shapes, quarter-wave table read, sign and square, cube multiply, output
// select. Throughput is one item per clock while rsp_if.ready is high; an item
// is registered in stages a, b, c and d in turn and then in the output register,
// whose valid bit drives rsp_if.valid. Stages hold independently, so a stalled
// output register still lets items enter until every stage is full. The shape
// register should be written while no item is in flight.
module periodic_waveform_shaper
   import pws_pkg::*;
#(
   parameter int PHASE_BITS  = PHASE_BITS_DEF,
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
   parameter int TABLE_BITS  = TABLE_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   pws_req_if.sink               req_if,
   pws_rsp_if.source             rsp_if,
   input  logic                  csr_wr_en,
   input  logic [SHAPE_BITS-1:0] csr_wr_data
);

   localparam int PB = PHASE_BITS;
   localparam int SB = SAMPLE_BITS;
   localparam int TB = TABLE_BITS;
   localparam logic [PB-1:0]        HALF_P  = PB'(1) << (PB - 1);
   localparam logic [PB-1:0]        QUART_P = PB'(1) << (PB - 2);
   localparam logic [TB:0]          TBL_N   = (TB+1)'(1) << TB;
   localparam logic signed [SB-1:0] MAX_S   = {1'b0, {(SB-1){1'b1}}};
   localparam logic signed [SB-1:0] MIN_S   = {1'b1, {(SB-1){1'b0}}};

   shape_type shape_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         shape_ff <= SHAPE_SINE;
      end else if (csr_wr_en) begin
         shape_ff <= shape_type'(csr_wr_data);
      end
   end

   // per-stage advance, a stage moves when empty or when the next one moves
   logic a_vld_ff, b_vld_ff, c_vld_ff, d_vld_ff, e_vld_ff;
   logic adv_a, adv_b, adv_c, adv_d, adv_e;

   assign adv_e = !e_vld_ff || rsp_if.ready;
   assign adv_d = !d_vld_ff || adv_e;
   assign adv_c = !c_vld_ff || adv_d;
   assign adv_b = !b_vld_ff || adv_c;
   assign adv_a = !a_vld_ff || adv_b;
   assign req_if.ready = adv_a;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
         b_vld_ff <= 1'b0;
         c_vld_ff <= 1'b0;
         d_vld_ff <= 1'b0;
         e_vld_ff <= 1'b0;
      end else begin
         if (adv_a) a_vld_ff <= req_if.valid;
         if (adv_b) b_vld_ff <= a_vld_ff;
         if (adv_c) c_vld_ff <= b_vld_ff;
         if (adv_d) d_vld_ff <= c_vld_ff;
         if (adv_e) e_vld_ff <= d_vld_ff;
      end
   end

   // stage a: table index and the shapes that need no table
   logic [PB-1:0]        p;
   logic [PB+TB-3:0]     jwide;
   logic [TB:0]          j;
   logic [PB+SB-1:0]     spwide;
   logic [SB-1:0]        sp;
   logic [PB-1:0]        q, d;
   logic [PB+SB:0]       twide;
   logic [SB:0]          tsc;
   logic signed [SB-1:0] saw;
   logic [TB:0]          a_idx_in, a_idx_ff;
   logic                 a_neg_in, a_neg_ff;
   logic signed [SB-1:0] a_simple_in, a_simple_ff;

   always_comb begin
      p        = req_if.phase;
      jwide    = {p[PB-3:0], TB'(0)};
      j        = {1'b0, jwide[PB+TB-3 -: TB]};
      a_idx_in = p[PB-2] ? TBL_N - j : j;
      a_neg_in = p[PB-1];
      spwide   = {p, SB'(0)};
      sp       = spwide[PB+SB-1 -: SB];
      saw      = {~sp[SB-1], sp[SB-2:0]};
      q        = p + QUART_P;
      d        = (q > HALF_P) ? q - HALF_P : HALF_P - q;
      twide    = {d, (SB+1)'(0)};
      tsc      = twide[PB+SB -: SB+1];
      case (shape_ff)
         SHAPE_RECT: a_simple_in = (p <= HALF_P) ? MAX_S : MIN_S;
         SHAPE_SAW:  a_simple_in = saw;
         SHAPE_ISAW: a_simple_in = (sp == '0) ? MAX_S : -saw;
         SHAPE_TRI:  a_simple_in = tsc[SB] ? MAX_S : {~tsc[SB-1], tsc[SB-2:0]};
         default:    a_simple_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (adv_a) begin
         a_idx_ff    <= a_idx_in;
         a_neg_ff    <= a_neg_in;
         a_simple_ff <= a_simple_in;
      end
   end

   // stage b: quarter-wave table read
   logic [SB-2:0]        b_tbl;
   logic                 b_neg_ff;
   logic signed [SB-1:0] b_simple_ff;

   pws_sine_rom #(
      .TABLE_BITS  (TB),
      .SAMPLE_BITS (SB)
   ) u_rom (
      .clock   (clock),
      .rd_en   (adv_b),
      .rd_addr (a_idx_ff),
      .rd_data (b_tbl)
   );

   always_ff @(posedge clock) begin
      if (adv_b) begin
         b_neg_ff    <= a_neg_ff;
         b_simple_ff <= a_simple_ff;
      end
   end

   // stage c: signed sine and its square
   logic signed [SB-1:0]   c_s_in, c_s_ff;
   logic signed [2*SB-1:0] c_prod_in, c_prod_ff;
   logic signed [SB-1:0]   c_simple_ff;

   always_comb begin
      c_s_in    = b_neg_ff ? -$signed({1'b0, b_tbl}) : $signed({1'b0, b_tbl});
      c_prod_in = c_s_in * c_s_in;
   end

   always_ff @(posedge clock) begin
      if (adv_c) begin
         c_s_ff      <= c_s_in;
         c_prod_ff   <= c_prod_in;
         c_simple_ff <= b_simple_ff;
      end
   end

   // stage d: square shifted down, then times the sine
   logic signed [SB-1:0]   d_sq_in, d_sq_ff, d_s_ff, d_simple_ff;
   logic signed [2*SB-1:0] d_prod_in, d_prod_ff;

   always_comb begin
      d_sq_in   = $signed(c_prod_ff[2*SB-2 -: SB]);
      d_prod_in = d_sq_in * c_s_ff;
   end

   always_ff @(posedge clock) begin
      if (adv_d) begin
         d_sq_ff     <= d_sq_in;
         d_s_ff      <= c_s_ff;
         d_prod_ff   <= d_prod_in;
         d_simple_ff <= c_simple_ff;
      end
   end

   // stage e: output register
   logic signed [SB-1:0] e_sample_in, e_sample_ff;

   always_comb begin
      case (shape_ff)
         SHAPE_SINE: e_sample_in = d_s_ff;
         SHAPE_SQR:  e_sample_in = d_sq_ff;
         SHAPE_CUBE: e_sample_in = $signed(d_prod_ff[2*SB-2 -: SB]);
         default:    e_sample_in = d_simple_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (adv_e) begin
         e_sample_ff <= e_sample_in;
      end
   end

   assign rsp_if.valid  = e_vld_ff;
   assign rsp_if.sample = e_sample_ff;

endmodule

FILE: sim/tb_periodic_waveform_shaper.sv
module tb_periodic_waveform_shaper
   import pws_pkg::*;
;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int PW      = PHASE_BITS_DEF;
   localparam int SW      = SAMPLE_BITS_DEF;
   localparam int TW      = TABLE_BITS_DEF;
   localparam int LUT_N   = 1 << TW;
   localparam longint FULL_SCALE = longint'(1) << (SW - 1);
   localparam longint MAX_SAMPLE = FULL_SCALE - 1;
   localparam longint HALF_TURN  = longint'(1) << (PW - 1);
   localparam longint QUARTER    = longint'(1) << (PW - 2);
   localparam longint PHASE_MASK = (longint'(1) << PW) - 1;
   localparam bit [63:0] HALF_PI_Q60 = 64'h1921FB54442D1846;

   localparam int RANDOM_ITEMS  = 1550;
   localparam int RANDOM_GROUPS = 16;

   class sample_tracker;
      longint                lut [0:LUT_N];
      shape_type             shape;
      logic signed [SW-1:0]  pending [$];
      int                    errors;
      int                    checked;

      function bit [63:0] mul_q60(bit [63:0] a, bit [63:0] b);
         bit [63:0] ah, al, bh, bl, mid;
         ah = a >> 32;
         al = a & 64'hFFFF_FFFF;
         bh = b >> 32;
         bl = b & 64'hFFFF_FFFF;
         mid = ah * bl + al * bh;
         return ((ah * bh) << 4) + (mid >> 28) + ((al * bl) >> 60);
      endfunction

      function new();
         bit [63:0] x, x2, term, sum, v;
         for (int k = 0; k <= LUT_N; k++) begin
            x = mul_q60(HALF_PI_Q60, 64'(k) << (60 - TW));
            x2 = mul_q60(x, x);
            term = x;
            sum = x;
            // taylor series of sin in unsigned q60
            for (int n = 1; n <= 12; n++) begin
               term = mul_q60(term, x2) / 64'((2 * n) * (2 * n + 1));
               if (n % 2 == 1) begin
                  sum = sum - term;
               end else begin
                  sum = sum + term;
               end
            end
            v = ((sum >> 20) * 64'(MAX_SAMPLE) + (64'd1 << 39)) >> 40;
            if (v > 64'(MAX_SAMPLE)) begin
               v = 64'(MAX_SAMPLE);
            end
            lut[k] = longint'(v);
         end
         shape = SHAPE_SINE;
         errors = 0;
         checked = 0;
      endfunction

      function longint sine_of(logic [PW-1:0] p);
         logic [1:0] quad;
         longint     j;
         quad = p[PW-1 -: 2];
         j = (longint'(p) & (QUARTER - 1)) >> (PW - 2 - TW);
         if (quad[0]) begin
            j = LUT_N - j;
         end
         return quad[1] ? -lut[j] : lut[j];
      endfunction

      function logic signed [SW-1:0] predict_sample(logic [PW-1:0] p);
         longint r, s, q, d, sp;
         sp = longint'(p) << (SW - PW);
         case (shape)
            SHAPE_SINE: r = sine_of(p);
            SHAPE_RECT: r = (longint'(p) <= HALF_TURN) ? MAX_SAMPLE : -FULL_SCALE;
            SHAPE_SAW:  r = sp - FULL_SCALE;
            SHAPE_ISAW: r = FULL_SCALE - sp;
            SHAPE_TRI: begin
               q = (longint'(p) + QUARTER) & PHASE_MASK;
               d = (q > HALF_TURN) ? q - HALF_TURN : HALF_TURN - q;
               r = (d << (SW - PW + 1)) - FULL_SCALE;
            end
            SHAPE_SQR: begin
               s = sine_of(p);
               r = (s * s) >>> (SW - 1);
            end
            SHAPE_CUBE: begin
               s = sine_of(p);
               r = (((s * s) >>> (SW - 1)) * s) >>> (SW - 1);
            end
            default: r = 0;
         endcase
         if (r > MAX_SAMPLE) begin
            r = MAX_SAMPLE;
         end else if (r < -FULL_SCALE) begin
            r = -FULL_SCALE;
         end
         return r[SW-1:0];
      endfunction

      task report_mismatch(string msg);
         $display("ERROR %0t: %s", $realtime, msg);
         errors++;
      endtask

      function void note_phase(logic [PW-1:0] p);
         pending.push_back(predict_sample(p));
      endfunction

      task check_sample(logic signed [SW-1:0] got);
         logic signed [SW-1:0] want;
         if (pending.size() == 0) begin
            report_mismatch($sformatf("sample %0d with no item pending", got));
         end else begin
            want = pending.pop_front();
            checked++;
            if (got !== want) begin
               report_mismatch($sformatf("sample %0d, expected %0d (shape %s)",
                                         got, want, shape.name()));
            end
         end
      endtask
   endclass

   logic clock;
   logic reset;
   logic csr_wr_en;
   logic [SHAPE_BITS-1:0] csr_wr_data;
   bit tx_quiet;
   bit rx_quiet;
   int settings;

   sample_tracker tracker;

   pws_req_if #(.PHASE_BITS(PW))  req_bus ();
   pws_rsp_if #(.SAMPLE_BITS(SW)) rsp_bus ();

   periodic_waveform_shaper #(
      .PHASE_BITS  (PW),
      .SAMPLE_BITS (SW),
      .TABLE_BITS  (TW)
   ) u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_bus),
      .rsp_if      (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial clock = 1'b0;
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   task automatic send_phase(logic [PW-1:0] p);
      int gap;
      gap = tx_quiet ? 0 : $urandom_range(0, 5);
      repeat (gap) begin
         @(negedge clock);
         req_bus.valid <= 1'b0;
      end
      @(negedge clock);
      req_bus.valid <= 1'b1;
      req_bus.phase <= p;
      do @(posedge clock); while (!(req_bus.valid && req_bus.ready === 1'b1));
      tracker.note_phase(p);
   endtask

   task automatic drain();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (tracker.pending.size() != 0) @(posedge clock);
   endtask

   task automatic set_shape(shape_type s);
      drain();
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= s;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      tracker.shape = s;
      settings++;
   endtask

   task automatic probe(shape_type s, logic [PW-1:0] p);
      if (s != tracker.shape) begin
         set_shape(s);
      end
      send_phase(p);
   endtask

   function automatic logic [PW-1:0] corner_phase();
      longint v;
      // quadrant boundaries and their neighbors, wrapping below zero
      v = QUARTER * $urandom_range(0, 3) + $urandom_range(0, 2) - 1;
      return v[PW-1:0];
   endfunction

   // result side: random stall before each item, then hold ready until accepted
   initial begin : rsp_side
      int stall;
      rsp_bus.ready = 1'b0;
      forever begin
         stall = rx_quiet ? 0 : $urandom_range(0, 5);
         repeat (stall) begin
            @(negedge clock);
            rsp_bus.ready <= 1'b0;
         end
         @(negedge clock);
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_bus.valid === 1'b1 && rsp_bus.ready));
         tracker.check_sample(rsp_bus.sample);
      end
   end

   initial begin : stimulus
      int        count;
      int        sent;
      shape_type sel;
      bit        sweep;
      logic [PW-1:0] acc;
      logic [PW-1:0] step;
      logic [PW-1:0] p;

      tracker = new();
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.phase = '0;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      tx_quiet = 1'b0;
      rx_quiet = 1'b0;
      settings = 0;
      sent = 0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: field extremes and the edges of each shape
      set_shape(SHAPE_SINE);
      probe(SHAPE_SINE, 16'd0);
      probe(SHAPE_SINE, 16'd16383);
      probe(SHAPE_SINE, 16'd16384);
      probe(SHAPE_SINE, 16'd32768);
      probe(SHAPE_SINE, 16'd49152);
      probe(SHAPE_SINE, 16'd65535);
      probe(SHAPE_RECT, 16'd32768);
      probe(SHAPE_RECT, 16'd32769);
      probe(SHAPE_RECT, 16'd65535);
      probe(SHAPE_SAW, 16'd0);
      probe(SHAPE_SAW, 16'd65535);
      probe(SHAPE_ISAW, 16'd0);
      probe(SHAPE_ISAW, 16'd1);
      probe(SHAPE_ISAW, 16'd65535);
      probe(SHAPE_TRI, 16'd0);
      probe(SHAPE_TRI, 16'd16384);
      probe(SHAPE_TRI, 16'd49152);
      probe(SHAPE_TRI, 16'd32768);
      probe(SHAPE_SQR, 16'd16384);
      probe(SHAPE_SQR, 16'd49152);
      probe(SHAPE_CUBE, 16'd49152);
      probe(SHAPE_CUBE, 16'd1);
      probe(SHAPE_CUBE, 16'd65535);
      probe(SHAPE_ZERO, 16'd65535);

      // random: first pass walks every shape in order, then random settings
      for (int g = 0; g < RANDOM_GROUPS; g++) begin
         sel = (g < 8) ? shape_type'(g) : shape_type'($urandom_range(0, 7));
         set_shape(sel);
         tx_quiet = ($urandom_range(0, 3) == 0);
         rx_quiet = ($urandom_range(0, 3) == 0);
         sweep = ($urandom_range(0, 1) == 1);
         acc = PW'($urandom_range(0, 65535));
         step = PW'($urandom_range(1, 4095));
         count = $urandom_range(RANDOM_ITEMS / RANDOM_GROUPS - 25,
                                RANDOM_ITEMS / RANDOM_GROUPS + 25);
         for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 6) == 0) begin
               p = corner_phase();
            end else if (sweep) begin
               acc = acc + step;
               p = acc;
            end else begin
               p = PW'($urandom_range(0, 65535));
            end
            send_phase(p);
            sent++;
         end
      end

      drain();
      repeat (10) @(posedge clock);
      if (tracker.pending.size() != 0) begin
         tracker.report_mismatch($sformatf("%0d samples never arrived",
                                           tracker.pending.size()));
      end
      $display("checked %0d samples (%0d random) across %0d shape register writes",
               tracker.checked, sent, settings);
      $display("all eight shapes, quadrant edges, phase sweeps and stalls on both sides");
      if (tracker.errors == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   initial begin : watchdog
      #3_000_000;
      $display("Verification failed");
      $finish;
   end

endmodule

FILE: periodic_waveform_shaper.f
rtl/pws_pkg.sv
rtl/pws_req_if.sv
rtl/pws_rsp_if.sv
rtl/pws_sine_rom.sv
rtl/periodic_waveform_shaper.sv
sim/tb_periodic_waveform_shaper.sv
